FILE: rtl/core/vwd_pkg.sv
// Shared constants, codes and control types for the vertex weld block.
package vwd_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int HASH_SLOTS   = 2048;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int SLOT_W       = $clog2(HASH_SLOTS);
  localparam int SLOT_DW      = 1 + 96 + IDX_W;

  localparam logic [31:0] HASH_CX = 32'd73856093;
  localparam logic [31:0] HASH_CY = 32'd19349663;
  localparam logic [31:0] HASH_CZ = 32'd83492791;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMAP  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NOIDX = 2'd2;

  localparam logic [2:0] RS_OK    = 3'd0;
  localparam logic [2:0] RS_FULL  = 3'd1;
  localparam logic [2:0] RS_NOIDX = 3'd2;
  localparam logic [2:0] RS_ZERO  = 3'd3;
  localparam logic [2:0] RS_REMAP = 3'd4;

  typedef struct packed {
    logic       capture;
    logic       k_clr;
    logic       qmul;
    logic       qrnd;
    logic       hmul;
    logic       slot_rd;
    logic       probe_next;
    logic       slot_ins;
    logic       remap_add;
    logic       remap_rd;
    logic       sweep_clr;
    logic       sweep_step;
    logic       out_load;
    logic [2:0] res_sel;
  } vwd_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       k_last;
    logic       ins_full;
    logic       uniq_full;
    logic       slot_valid;
    logic       slot_match;
    logic       probe_last;
    logic       vi_ok;
    logic       sweep_last;
  } vwd_sts_t;

endpackage

FILE: rtl/core/vwd_dp.sv
// Datapath: quantizer, hash, probe slot table, remap store and result register.
module vwd_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  vwd_pkg::vwd_cmd_t      cmd,
  output vwd_pkg::vwd_sts_t      sts,
  input  logic                   cfg_valid,
  input  logic [31:0]            cfg_data,
  input  logic [1:0]             in_operation,
  input  logic signed [31:0]     in_coord_x,
  input  logic signed [31:0]     in_coord_y,
  input  logic signed [31:0]     in_coord_z,
  input  logic [9:0]             in_vertex_index,
  output logic [9:0]             out_unique_index,
  output logic                   out_is_new,
  output logic [1:0]             out_status
);
  import vwd_pkg::*;

  logic [31:0]        scale_r;
  logic [1:0]         op_r;
  logic [31:0]        cx_r, cy_r, cz_r;
  logic [IDX_W-1:0]   vidx_r;
  logic [1:0]         k_r;
  logic [63:0]        prod_r;
  logic               neg_r;
  logic [31:0]        raw_r;
  logic [31:0]        key_r [0:2];
  logic [31:0]        h_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [SLOT_W-1:0]  n_r;
  logic [SLOT_W-1:0]  sweep_r;
  logic [CNT_W-1:0]   ins_r;
  logic [CNT_W-1:0]   uniq_r;
  logic [IDX_W-1:0]   idx_r;
  logic               new_r;
  logic [SLOT_DW-1:0] slot_mem [0:HASH_SLOTS-1];
  logic [SLOT_DW-1:0] slot_rd_r;
  logic [IDX_W-1:0]   remap_mem [0:MAX_VERTICES-1];
  logic [IDX_W-1:0]   remap_rd_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic               out_new_r;
  logic [1:0]         out_sts_r;

  logic [31:0]        coord_sel, mag, key_sel, coef_sel, hprod, h_nxt, r, rn, q, key_nxt;
  logic [63:0]        prod_nxt, rsum;
  logic               neg;
  logic               slot_we;
  logic [SLOT_W-1:0]  slot_wa;
  logic [SLOT_DW-1:0] slot_wd;
  logic [IDX_W-1:0]   add_idx;

  always_comb begin
    case (k_r)
      2'd0:    begin coord_sel = cx_r; coef_sel = HASH_CX; end
      2'd1:    begin coord_sel = cy_r; coef_sel = HASH_CY; end
      default: begin coord_sel = cz_r; coef_sel = HASH_CZ; end
    endcase
    neg      = coord_sel[31];
    mag      = neg ? (32'd0 - coord_sel) : coord_sel;
    prod_nxt = 64'(mag) * 64'(scale_r);
    rsum     = prod_r + 64'h0000_0000_8000_0000;
    r        = rsum[63:32];
    if (neg_r) begin
      rn = (r > 32'h8000_0000) ? 32'h8000_0000 : r;
      q  = 32'd0 - rn;
    end else begin
      rn = r;
      q  = (r > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : r;
    end
    key_nxt = (scale_r == 32'd0) ? raw_r : q;
    key_sel = key_r[k_r];
    hprod   = key_sel * coef_sel;
    h_nxt   = (k_r == 2'd0) ? hprod : (h_r ^ hprod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 32'd0;
    end else if (cfg_valid) begin
      scale_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_operation;
      cx_r   <= in_coord_x;
      cy_r   <= in_coord_y;
      cz_r   <= in_coord_z;
      vidx_r <= in_vertex_index;
    end
    if (cmd.qmul) begin
      prod_r <= prod_nxt;
      neg_r  <= neg;
      raw_r  <= coord_sel;
    end
    if (cmd.qrnd) begin
      key_r[k_r] <= key_nxt;
    end
    if (cmd.hmul) begin
      h_r    <= h_nxt;
      slot_r <= h_nxt[SLOT_W-1:0];
      n_r    <= '0;
    end else if (cmd.probe_next) begin
      slot_r <= slot_r + 1'b1;
      n_r    <= n_r + 1'b1;
    end
    if (cmd.remap_add) begin
      idx_r <= add_idx;
      new_r <= cmd.slot_ins;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= 2'd0;
      sweep_r <= '0;
      ins_r   <= '0;
      uniq_r  <= '0;
    end else begin
      if (cmd.k_clr) begin
        k_r <= 2'd0;
      end else if (cmd.hmul) begin
        k_r <= k_r + 2'd1;
      end
      if (cmd.sweep_clr) begin
        sweep_r <= '0;
        ins_r   <= '0;
        uniq_r  <= '0;
      end else begin
        if (cmd.sweep_step) begin
          sweep_r <= sweep_r + 1'b1;
        end
        if (cmd.slot_ins) begin
          uniq_r <= uniq_r + 1'b1;
        end
        if (cmd.remap_add) begin
          ins_r <= ins_r + 1'b1;
        end
      end
    end
  end

  assign add_idx = cmd.slot_ins ? uniq_r[IDX_W-1:0] : slot_rd_r[IDX_W-1:0];
  assign slot_we = cmd.sweep_step | cmd.slot_ins;
  assign slot_wa = cmd.sweep_step ? sweep_r : slot_r;
  assign slot_wd = cmd.sweep_step ? '0 :
                   {1'b1, key_r[0], key_r[1], key_r[2], uniq_r[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (cmd.slot_rd) begin
      slot_rd_r <= slot_mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.remap_add) begin
      remap_mem[ins_r[IDX_W-1:0]] <= add_idx;
    end
    if (cmd.remap_rd) begin
      remap_rd_r <= remap_mem[vidx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.res_sel)
        RS_OK:    begin out_idx_r <= idx_r;      out_new_r <= new_r; out_sts_r <= ST_OK;    end
        RS_FULL:  begin out_idx_r <= '0;         out_new_r <= 1'b0;  out_sts_r <= ST_FULL;  end
        RS_NOIDX: begin out_idx_r <= '0;         out_new_r <= 1'b0;  out_sts_r <= ST_NOIDX; end
        RS_REMAP: begin out_idx_r <= remap_rd_r; out_new_r <= 1'b0;  out_sts_r <= ST_OK;    end
        default:  begin out_idx_r <= '0;         out_new_r <= 1'b0;  out_sts_r <= ST_OK;    end
      endcase
    end
  end

  assign out_unique_index = out_idx_r;
  assign out_is_new       = out_new_r;
  assign out_status       = out_sts_r;

  assign sts.op         = op_r;
  assign sts.k_last     = (k_r == 2'd2);
  assign sts.ins_full   = (ins_r == CNT_W'(MAX_VERTICES));
  assign sts.uniq_full  = (uniq_r == CNT_W'(MAX_VERTICES));
  assign sts.slot_valid = slot_rd_r[SLOT_DW-1];
  assign sts.slot_match = (slot_rd_r[IDX_W+95:IDX_W+64] == key_r[0]) &&
                          (slot_rd_r[IDX_W+63:IDX_W+32] == key_r[1]) &&
                          (slot_rd_r[IDX_W+31:IDX_W]    == key_r[2]);
  assign sts.probe_last = (n_r == {SLOT_W{1'b1}});
  assign sts.vi_ok      = (CNT_W'(vidx_r) < ins_r);
  assign sts.sweep_last = (sweep_r == {SLOT_W{1'b1}});

endmodule

FILE: rtl/core/vwd_ctrl.sv
// Controller state machine: sequences quantize, hash, probe, remap and clear.
module vwd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  vwd_pkg::vwd_sts_t sts,
  output vwd_pkg::vwd_cmd_t cmd
);
  import vwd_pkg::*;

  localparam logic [3:0] S_SWR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DISP = 4'd2;
  localparam logic [3:0] S_QMUL = 4'd3;
  localparam logic [3:0] S_QRND = 4'd4;
  localparam logic [3:0] S_HMUL = 4'd5;
  localparam logic [3:0] S_PRD  = 4'd6;
  localparam logic [3:0] S_PCMP = 4'd7;
  localparam logic [3:0] S_RMRD = 4'd8;
  localparam logic [3:0] S_SWC  = 4'd9;
  localparam logic [3:0] S_RESP = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [2:0] res_r, res_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    cmd           = '0;
    cmd.res_sel   = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_SWR: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          OP_INSERT: begin
            if (sts.ins_full) begin
              res_nxt   = RS_FULL;
              state_nxt = S_RESP;
            end else begin
              cmd.k_clr = 1'b1;
              state_nxt = S_QMUL;
            end
          end
          OP_REMAP: state_nxt = S_RMRD;
          OP_CLEAR: begin
            cmd.sweep_clr = 1'b1;
            state_nxt     = S_SWC;
          end
          default: begin
            res_nxt   = RS_ZERO;
            state_nxt = S_RESP;
          end
        endcase
      end
      S_QMUL: begin
        cmd.qmul  = 1'b1;
        state_nxt = S_QRND;
      end
      S_QRND: begin
        cmd.qrnd  = 1'b1;
        state_nxt = S_HMUL;
      end
      S_HMUL: begin
        cmd.hmul  = 1'b1;
        state_nxt = sts.k_last ? S_PRD : S_QMUL;
      end
      S_PRD: begin
        cmd.slot_rd = 1'b1;
        state_nxt   = S_PCMP;
      end
      S_PCMP: begin
        state_nxt = S_RESP;
        if (sts.slot_valid && sts.slot_match) begin
          cmd.remap_add = 1'b1;
          res_nxt       = RS_OK;
        end else if (sts.slot_valid) begin
          if (sts.probe_last) begin
            res_nxt = RS_FULL;
          end else begin
            cmd.probe_next = 1'b1;
            state_nxt      = S_PRD;
          end
        end else if (sts.uniq_full) begin
          res_nxt = RS_FULL;
        end else begin
          cmd.slot_ins  = 1'b1;
          cmd.remap_add = 1'b1;
          res_nxt       = RS_OK;
        end
      end
      S_RMRD: begin
        if (sts.vi_ok) begin
          cmd.remap_rd = 1'b1;
          res_nxt      = RS_REMAP;
        end else begin
          res_nxt = RS_NOIDX;
        end
        state_nxt = S_RESP;
      end
      S_SWC: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          res_nxt   = RS_ZERO;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWR;
      res_r       <= RS_ZERO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.slot_ins |-> !sts.uniq_full) else $error("slot insert past vertex capacity");
  a_remap_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.remap_add |-> !sts.ins_full) else $error("remap write past capacity");
  a_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.sweep_step && cmd.slot_ins)) else $error("sweep and insert collide");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready)) else $error("result overwritten");

endmodule

FILE: rtl/core/vertex_weld_dedup_top.sv
// Top level of the vertex weld block: controller and datapath.
// Insert: P slots are probed from transfer to result, P = 1..2048;
// no slot is probed when vertex capacity is full.
// Clear includes a slot table sweep.
// One item at a time; next item is taken while the last result waits.
// Reset (rst_n low, synchronous) clears scale and counters, then sweeps
// the 2048-entry slot table with in_ready low.
module vertex_weld_dedup_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  input  logic [9:0]         in_vertex_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         out_unique_index,
  output logic               out_is_new,
  output logic [1:0]         out_status
);
  import vwd_pkg::*;

  vwd_cmd_t cmd;
  vwd_sts_t sts;

  assign cfg_ready = 1'b1;

  vwd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vwd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .in_operation     (in_operation),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_coord_z       (in_coord_z),
    .in_vertex_index  (in_vertex_index),
    .out_unique_index (out_unique_index),
    .out_is_new       (out_is_new),
    .out_status       (out_status)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the vertex weld block, with an in-bench predictor.
`timescale 1ns / 1ps

module tb_top;
  import vwd_pkg::*;

  localparam int LIMIT = 3000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] x, y, z;
    logic [9:0]  vi;
  } vertex_req_t;

  typedef struct {
    logic [9:0] uidx;
    logic       fresh;
    logic [1:0] status;
  } weld_res_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_operation = OP_INSERT;
  logic signed [31:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0;
  logic [9:0] in_vertex_index = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [9:0] out_unique_index;
  logic out_is_new;
  logic [1:0] out_status;

  vertex_weld_dedup_top dut (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_data,
    .in_valid, .in_ready, .in_operation, .in_coord_x, .in_coord_y, .in_coord_z,
    .in_vertex_index, .out_valid, .out_ready, .out_unique_index, .out_is_new, .out_status
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // predictor state
  logic [31:0] scale_q = '0;
  logic        slot_used [HASH_SLOTS];
  logic [31:0] slot_kx [HASH_SLOTS], slot_ky [HASH_SLOTS], slot_kz [HASH_SLOTS];
  logic [9:0]  slot_uid [HASH_SLOTS];
  logic [9:0]  remap_tab [MAX_VERTICES];
  int          n_inserted = 0, n_unique = 0;

  vertex_req_t pend_q [$];
  weld_res_t   weld_q [$];
  int          errors = 0;
  int          cyc = 0;

  function automatic logic [31:0] quantize(logic [31:0] bits);
    logic        neg;
    logic [63:0] mag, r;
    if (scale_q == 0) return bits;
    neg = bits[31];
    mag = {32'd0, neg ? -bits : bits};
    mag = mag * {32'd0, scale_q};
    r = (mag + 64'h8000_0000) >> 32;
    if (neg) begin
      if (r > 64'h8000_0000) r = 64'h8000_0000;
      return -r[31:0];
    end
    if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
    return r[31:0];
  endfunction

  function automatic weld_res_t weld_predict(vertex_req_t it);
    weld_res_t   res;
    logic [31:0] kx, ky, kz, h;
    int          slot;
    bit          done;
    res = '{uidx: '0, fresh: 1'b0, status: ST_OK};
    if (it.op == OP_INSERT) begin
      kx = quantize(it.x);
      ky = quantize(it.y);
      kz = quantize(it.z);
      h = (kx * HASH_CX) ^ (ky * HASH_CY) ^ (kz * HASH_CZ);
      slot = h % HASH_SLOTS;
      done = 0;
      res.status = ST_FULL;
      if (n_inserted < MAX_VERTICES) begin
        for (int n = 0; n < HASH_SLOTS && !done; n++) begin
          if (slot_used[slot]) begin
            if (slot_kx[slot] == kx && slot_ky[slot] == ky && slot_kz[slot] == kz) begin
              res.uidx = slot_uid[slot];
              res.status = ST_OK;
              done = 1;
            end
          end else begin
            if (n_unique < MAX_VERTICES) begin
              slot_used[slot] = 1;
              slot_kx[slot] = kx;
              slot_ky[slot] = ky;
              slot_kz[slot] = kz;
              slot_uid[slot] = n_unique[9:0];
              res.uidx = n_unique[9:0];
              n_unique++;
              res.fresh = 1;
              res.status = ST_OK;
            end
            done = 1;
          end
          slot = (slot + 1) % HASH_SLOTS;
        end
        if (res.status == ST_OK) begin
          remap_tab[n_inserted] = res.uidx;
          n_inserted++;
        end
      end
      if (res.status != ST_OK) begin
        res.uidx = '0;
        res.fresh = 0;
      end
    end else if (it.op == OP_REMAP) begin
      if (it.vi < n_inserted) res.uidx = remap_tab[it.vi];
      else res.status = ST_NOIDX;
    end else if (it.op == OP_CLEAR) begin
      foreach (slot_used[i]) slot_used[i] = 0;
      n_inserted = 0;
      n_unique = 0;
    end
    return res;
  endfunction

  // sender: bursts and gaps
  vertex_req_t cur;
  int burst_left = 4, gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      if (in_valid && in_ready) weld_q = {weld_q, weld_predict(cur)};
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 0;
        end else if (pend_q.size() > 0) begin
          cur = pend_q.pop_front();
          in_operation <= cur.op;
          in_coord_x <= cur.x;
          in_coord_y <= cur.y;
          in_coord_z <= cur.z;
          in_vertex_index <= cur.vi;
          in_valid <= 1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // receiver stall pattern and run limit
  logic [31:0] stall_pat = '1;
  logic        calm = 1;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc[7:0] == 0) begin
      stall_pat = $urandom();
      calm = ($urandom_range(0, 2) == 0);
    end
    out_ready <= calm | stall_pat[cyc[4:0]];
    if (cyc > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cyc);
    errors++;
  endtask

  always @(posedge clk) begin
    weld_res_t w;
    if (rst_n && out_valid && out_ready) begin
      if (weld_q.size() == 0) begin
        report("unexpected transfer", 32'(out_unique_index), 32'd0);
      end else begin
        w = weld_q.pop_front();
        if (out_unique_index !== w.uidx)
          report("unique_index", 32'(out_unique_index), 32'(w.uidx));
        if (out_is_new !== w.fresh) report("is_new", 32'(out_is_new), 32'(w.fresh));
        if (out_status !== w.status) report("status", 32'(out_status), 32'(w.status));
      end
    end
  end

  // stimulus
  vertex_req_t recent [$];
  int gen_count = 0;

  task automatic push_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    vertex_req_t item;
    item = '{op: OP_INSERT, x: x, y: y, z: z, vi: 10'($urandom())};
    pend_q = {pend_q, item};
    item.vi = '0;
    recent = {recent, item};
    if (recent.size() > 64) void'(recent.pop_front());
    gen_count++;
  endtask

  task automatic push_cmd(logic [1:0] op, logic [9:0] vi);
    vertex_req_t item;
    item = '{op: op, x: $urandom(), y: $urandom(), z: $urandom(), vi: vi};
    pend_q = {pend_q, item};
    if (op == OP_CLEAR) gen_count = 0;
  endtask

  function automatic logic [31:0] jitter(logic [31:0] v);
    return v + 32'(int'($urandom_range(0, 128)) - 64);
  endfunction

  task automatic push_random(int n);
    vertex_req_t p;
    int          roll, top;
    repeat (n) begin
      roll = $urandom_range(0, 199);
      if (roll < 60 && recent.size() > 0) begin
        p = recent[$urandom_range(0, recent.size() - 1)];
        if ($urandom_range(0, 1)) push_vertex(p.x, p.y, p.z);
        else push_vertex(jitter(p.x), jitter(p.y), jitter(p.z));
      end else if (roll < 120) begin
        push_vertex($urandom(), $urandom(), $urandom());
      end else if (roll < 175) begin
        top = (gen_count + 4 > 1023) ? 1023 : gen_count + 4;
        push_cmd(OP_REMAP, 10'($urandom_range(0, top)));
      end else if (roll < 190) begin
        push_cmd(OP_REMAP, 10'($urandom()));
      end else if (roll < 198) begin
        push_cmd(OP_UNUSED, 10'($urandom()));
      end else begin
        push_cmd(OP_CLEAR, '0);
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (pend_q.size() > 0 || in_valid || weld_q.size() > 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_scale(logic [31:0] v);
    cfg_data <= v;
    cfg_valid <= 1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    scale_q = v;
    cfg_valid <= 0;
    cfg_data <= '0;
  endtask

  initial begin
    foreach (slot_used[i]) slot_used[i] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    write_scale(32'd0);
    push_cmd(OP_REMAP, 10'd0);
    push_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    push_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    push_vertex(32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
    push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    push_cmd(OP_REMAP, 10'd2);
    push_cmd(OP_REMAP, 10'd4);
    push_cmd(OP_REMAP, 10'd5);
    push_cmd(OP_REMAP, 10'd1023);
    push_cmd(OP_UNUSED, 10'h3FF);
    push_cmd(OP_CLEAR, '0);
    push_cmd(OP_REMAP, 10'd0);
    push_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
    wait_idle();

    write_scale(32'hFFFF_FFFF);
    push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    push_vertex(32'h7FFF_0000, 32'h8000_0001, 32'h0000_0000);
    push_vertex(32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001);
    push_vertex(32'h0000_7FFF, 32'hFFFF_8001, 32'hFFFF_FFFF);
    push_random(100);
    wait_idle();

    write_scale(32'd1);
    push_random(100);
    wait_idle();

    write_scale(32'h0001_0000);
    push_cmd(OP_CLEAR, '0);
    push_vertex(32'h0000_8000, 32'hFFFF_8000, 32'h0001_7FFF);
    push_vertex(32'h0000_7FFF, 32'hFFFF_8001, 32'h0001_0000);
    push_random(150);
    wait_idle();

    write_scale($urandom());
    push_random(200);
    wait_idle();

    write_scale(32'h0000_8000);
    push_cmd(OP_CLEAR, '0);
    repeat (120) push_vertex($urandom(), $urandom(), $urandom());
    push_cmd(OP_REMAP, 10'd1023);
    push_cmd(OP_REMAP, 10'd0);
    push_random(20);
    push_cmd(OP_CLEAR, '0);
    push_random(40);
    wait_idle();

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/vwd_pkg.sv
rtl/core/vwd_dp.sv
rtl/core/vwd_ctrl.sv
rtl/core/vertex_weld_dedup_top.sv
tb/tb_top.sv
